[rtl/store_load_alias_flush_check_defines.svh]
// assertion macros for the load alias flush check
`ifndef STORE_LOAD_ALIAS_FLUSH_CHECK_DEFINES_SVH
`define STORE_LOAD_ALIAS_FLUSH_CHECK_DEFINES_SVH

// implication in the same cycle
`define SLAFC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slafc check failed");

// implication in the next cycle
`define SLAFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slafc check failed");

`endif

[rtl/slafc_pkg.sv]
// shared types and constants for the load alias flush check
package slafc_pkg;

    localparam int SEQ_W      = 48;
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 7;
    localparam int END_W      = 49;
    localparam int SLOT_W     = 4;
    localparam int MASK_W     = 16;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 72;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // running result handed along the row of cells
    typedef struct packed {
        logic             err;
        logic             dep;
        logic             found;
        logic [SEQ_W-1:0] seq;
    } acc_t;

    // slot write broadcast to the cells
    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [END_W-1:0]  lend;
        logic              issued;
        logic              bypass;
        logic              noncore;
    } slot_wr_t;

    // store range under check
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [END_W-1:0]  send;
    } store_t;

endpackage

[rtl/slafc_cell.sv]
// one load slot: holds its entry, tests overlap, merges into the running oldest alias
module slafc_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  slafc_pkg::slot_wr_t wr,
    input  slafc_pkg::store_t   st,
    input  slafc_pkg::acc_t     acc_in,
    output slafc_pkg::acc_t     acc_out,
    input  slafc_pkg::acc_t     result,
    output logic                flush
);

    logic                               valid_reg;
    logic [slafc_pkg::SEQ_W-1:0]        seq_reg;
    logic [slafc_pkg::ADDR_W-1:0]       addr_reg;
    logic [slafc_pkg::END_W-1:0]        lend_reg;
    logic                               issued_reg;
    logic                               bypass_reg;
    logic                               noncore_reg;
    logic                               hit_reg;
    logic                               err_reg;
    slafc_pkg::acc_t                    acc_reg;
    slafc_pkg::acc_t                    acc_next;
    logic                               overlap;
    logic                               elig;
    logic                               take;

    assign overlap = !((slafc_pkg::END_W'(st.addr) >= lend_reg) ||
                       (st.send <= slafc_pkg::END_W'(addr_reg)));
    assign elig    = valid_reg && issued_reg && !bypass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr.valid)
        begin
            seq_reg     <= wr.seq;
            addr_reg    <= wr.addr;
            lend_reg    <= wr.lend;
            issued_reg  <= wr.issued;
            bypass_reg  <= wr.bypass;
            noncore_reg <= wr.noncore;
        end
        hit_reg <= elig && overlap;
        err_reg <= valid_reg && issued_reg && bypass_reg && overlap;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        take           = hit_reg && (!acc_in.found || (seq_reg < acc_in.seq));
        acc_next.found = acc_in.found || hit_reg;
        acc_next.seq   = take ? seq_reg : acc_in.seq;
        acc_next.dep   = acc_in.dep || (hit_reg && noncore_reg);
        acc_next.err   = acc_in.err || err_reg;
    end

    assign acc_out = acc_reg;
    assign flush   = result.found && elig && (seq_reg >= result.seq) &&
                     (hit_reg || result.dep);

endmodule

[rtl/store_load_alias_flush_check.sv]
// top level: slot writes, store checks over a row of load slot cells
// a write transaction gives an all-zero result, registered in ST_DONE after acceptance
// a check transaction scans the row in ST_SCAN, builds its result in ST_FLUSH, offers it from ST_DONE
// one transaction at a time: s_tready is low until the result goes to the output register,
//   and a check scans while the running oldest-alias value walks the row, one cell per cycle
// reset: asynchronous active low, frees every slot and empties the output register
module store_load_alias_flush_check
#(
    parameter int ENTRIES = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slot[3:0] entry_valid[4] load_seq[52:5] addr[100:53] size[107:101]
    // issued[108] bypass[109] noncore_dep[110] zero[111]
    input  logic [slafc_pkg::IN_DATA_W-1:0]     s_tdata,
    // func
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // alias_found[0] oldest_alias_seq[48:1] flush_mask[64:49]
    // dep_forces_flush[65] bypass_alias_error[66] zero[71:67]
    output logic [slafc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CNT_W = $clog2(ENTRIES + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t                                 state_reg;
    logic [CNT_W-1:0]                       cnt_reg;
    logic                                   m_valid_reg;
    logic [slafc_pkg::OUT_DATA_W-1:0]       m_data_reg;
    logic [slafc_pkg::OUT_DATA_W-1:0]       res_reg;
    slafc_pkg::store_t                      st_reg;
    slafc_pkg::slot_wr_t                    wr;
    slafc_pkg::acc_t                        chain [ENTRIES+1];
    slafc_pkg::acc_t                        result;
    logic [ENTRIES-1:0]                     cell_flush;
    logic [ENTRIES-1:0]                     cell_wr;
    logic [slafc_pkg::MASK_W-1:0]           mask;
    logic [slafc_pkg::SLOT_W-1:0]           in_slot;
    logic [slafc_pkg::ADDR_W-1:0]           in_addr;
    logic [slafc_pkg::SIZE_W-1:0]           in_size;
    logic                                   in_accept;
    logic                                   out_free;

    assign in_slot     = s_tdata[3:0];
    assign in_addr     = s_tdata[100:53];
    assign in_size     = s_tdata[107:101];
    assign wr.valid    = s_tdata[4];
    assign wr.seq      = s_tdata[52:5];
    assign wr.addr     = in_addr;
    assign wr.lend     = slafc_pkg::END_W'(in_addr) + slafc_pkg::END_W'(in_size);
    assign wr.issued   = s_tdata[108];
    assign wr.bypass   = s_tdata[109];
    assign wr.noncore  = s_tdata[110];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign chain[0] = '0;
    assign result   = chain[ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign cell_wr[i] = in_accept && (s_tuser == slafc_pkg::FUNC_WRITE) &&
                            (32'(in_slot) == i);
        slafc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (cell_wr[i]),
            .wr      (wr),
            .st      (st_reg),
            .acc_in  (chain[i]),
            .acc_out (chain[i+1]),
            .result  (result),
            .flush   (cell_flush[i])
        );
    end

    for (genvar j = 0; j < slafc_pkg::MASK_W; j++)
    begin : g_mask
        if (j < ENTRIES)
        begin : g_on
            assign mask[j] = cell_flush[j];
        end
        else
        begin : g_off
            assign mask[j] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            st_reg.addr <= in_addr;
            st_reg.send <= slafc_pkg::END_W'(in_addr) + slafc_pkg::END_W'(in_size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            res_reg     <= '0;
        end
        else
        begin
            if (m_valid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_accept)
                    begin
                        res_reg <= '0;
                        if (s_tuser == slafc_pkg::FUNC_CHECK)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ENTRIES + 1))
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    res_reg   <= {5'b0, result.err, result.found && result.dep, mask,
                                  result.found ? result.seq : {slafc_pkg::SEQ_W{1'b0}},
                                  result.found};
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/slafc_checker.sv]
// port-level assertions for the load alias flush check, bound to the top level
`include "store_load_alias_flush_check_defines.svh"

module slafc_checker
#(
    parameter int ENTRIES = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [slafc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // one transaction in flight at a time
    `SLAFC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

    // stalled result holds
    `SLAFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // no alias means no sequence, mask or dependent flag
    `SLAFC_ASSERT_SAME(a_no_alias_zero, m_tvalid && !m_tdata[0], m_tdata[65:1] == 65'd0)

    // with at most 16 entries the oldest aliasing slot is always flushed, so the mask is not zero
    `SLAFC_ASSERT_SAME(a_alias_flushes, m_tvalid && m_tdata[0],
        (ENTRIES > 16) || (m_tdata[64:49] != 16'd0))

endmodule

bind store_load_alias_flush_check slafc_checker #(.ENTRIES(ENTRIES)) u_slafc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/store_load_alias_flush_check_tb.sv]
// self-checking testbench for the load alias flush check, directed and random slot writes and store checks
module store_load_alias_flush_check_tb;

    localparam int ENTRIES     = 16;
    localparam int HOLD_AFTER  = 300;
    localparam int RESULT_HOLD = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int CHUNKS      = 4;
    localparam int CHUNK_OPS   = 208;

    typedef struct {
        logic                         func;
        logic [slafc_pkg::SLOT_W-1:0] slot;
        logic                         fill;
        logic [slafc_pkg::SEQ_W-1:0]  seq;
        logic [slafc_pkg::ADDR_W-1:0] addr;
        logic [slafc_pkg::SIZE_W-1:0] size;
        logic                         issued;
        logic                         bypass;
        logic                         noncore;
    } load_op_t;

    typedef struct {
        logic                         found;
        logic [slafc_pkg::SEQ_W-1:0]  oldest;
        logic [slafc_pkg::MASK_W-1:0] mask;
        logic                         dep;
        logic                         err;
    } flush_result_t;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // slot, entry_valid, load_seq, addr, size, issued, bypass, noncore_dep, zero
    logic [slafc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    // func
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // alias_found, oldest_alias_seq, flush_mask, dep_forces_flush, bypass_alias_error, zero
    logic [slafc_pkg::OUT_DATA_W-1:0] m_tdata;

    load_op_t      pending_ops[$];
    flush_result_t expected_flushes[$];
    load_op_t      op_on_bus;

    bit                           tbl_valid   [ENTRIES];
    logic [slafc_pkg::SEQ_W-1:0]  tbl_seq     [ENTRIES];
    logic [slafc_pkg::ADDR_W-1:0] tbl_addr    [ENTRIES];
    logic [slafc_pkg::SIZE_W-1:0] tbl_size    [ENTRIES];
    logic                         tbl_issued  [ENTRIES];
    logic                         tbl_bypass  [ENTRIES];
    logic                         tbl_noncore [ENTRIES];

    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int tx_wait      = 0;
    int rx_wait      = 0;
    int hold_left    = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int write_count  = 0;
    int check_count  = 0;
    int alias_checks = 0;
    int dep_checks   = 0;
    int err_checks   = 0;
    int flushed_lds  = 0;

    store_load_alias_flush_check #(.ENTRIES(ENTRIES)) i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic bit ranges_touch(logic [slafc_pkg::ADDR_W-1:0] sa,
                                        logic [slafc_pkg::SIZE_W-1:0] ss,
                                        logic [slafc_pkg::ADDR_W-1:0] la,
                                        logic [slafc_pkg::SIZE_W-1:0] ls);
        logic [slafc_pkg::ADDR_W:0] s_end;
        logic [slafc_pkg::ADDR_W:0] l_end;
        s_end = {1'b0, sa} + (slafc_pkg::ADDR_W + 1)'(ss);
        l_end = {1'b0, la} + (slafc_pkg::ADDR_W + 1)'(ls);
        return !({1'b0, sa} >= l_end || s_end <= {1'b0, la});
    endfunction

    function automatic flush_result_t step_load_table(load_op_t op);
        flush_result_t r;
        r = '{default: '0};
        if (op.func == slafc_pkg::FUNC_WRITE)
        begin
            write_count++;
            if (op.fill)
            begin
                tbl_valid[op.slot]   = 1'b1;
                tbl_seq[op.slot]     = op.seq;
                tbl_addr[op.slot]    = op.addr;
                tbl_size[op.slot]    = op.size;
                tbl_issued[op.slot]  = op.issued;
                tbl_bypass[op.slot]  = op.bypass;
                tbl_noncore[op.slot] = op.noncore;
            end
            else
            begin
                tbl_valid[op.slot] = 1'b0;
            end
            return r;
        end
        check_count++;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!tbl_valid[i] || !tbl_issued[i])
                continue;
            if (!ranges_touch(op.addr, op.size, tbl_addr[i], tbl_size[i]))
                continue;
            if (tbl_bypass[i])
            begin
                r.err = 1'b1;
                continue;
            end
            if (!r.found || tbl_seq[i] < r.oldest)
                r.oldest = tbl_seq[i];
            r.found = 1'b1;
            if (tbl_noncore[i])
                r.dep = 1'b1;
        end
        if (r.found)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tbl_valid[i] && tbl_issued[i] && !tbl_bypass[i] && tbl_seq[i] >= r.oldest &&
                    (r.dep || ranges_touch(op.addr, op.size, tbl_addr[i], tbl_size[i])))
                    r.mask[i] = 1'b1;
            end
        end
        alias_checks += r.found;
        dep_checks   += r.dep;
        err_checks   += r.err;
        flushed_lds  += $countones(r.mask);
        return r;
    endfunction

    function automatic load_op_t write_op(int slot, bit fill, logic [slafc_pkg::SEQ_W-1:0] seq,
                                          logic [slafc_pkg::ADDR_W-1:0] addr, int size,
                                          bit issued, bit bypass, bit noncore);
        load_op_t op;
        op.func    = slafc_pkg::FUNC_WRITE;
        op.slot    = slafc_pkg::SLOT_W'(slot);
        op.fill    = fill;
        op.seq     = seq;
        op.addr    = addr;
        op.size    = slafc_pkg::SIZE_W'(size);
        op.issued  = issued;
        op.bypass  = bypass;
        op.noncore = noncore;
        return op;
    endfunction

    function automatic load_op_t check_op(logic [slafc_pkg::ADDR_W-1:0] addr, int size);
        load_op_t op;
        op      = write_op(0, 1'b0, '0, addr, size, 1'b0, 1'b0, 1'b0);
        op.func = slafc_pkg::FUNC_CHECK;
        return op;
    endfunction

    task automatic queue_op(load_op_t op);
        pending_ops = {pending_ops, op};
    endtask

    task automatic queue_random_ops(int count);
        logic [slafc_pkg::ADDR_W-1:0] bases [4];
        logic [slafc_pkg::SEQ_W-1:0]  seq_base;
        load_op_t                     op;
        bases[0] = '0;
        bases[1] = {slafc_pkg::ADDR_W{1'b1}} - 48'd127;
        bases[2] = rand48();
        bases[3] = rand48();
        seq_base = rand48();
        repeat (count)
        begin
            op.func    = ($urandom_range(0, 99) < 45) ? slafc_pkg::FUNC_CHECK
                                                      : slafc_pkg::FUNC_WRITE;
            op.slot    = slafc_pkg::SLOT_W'($urandom_range(0, ENTRIES - 1));
            op.fill    = $urandom_range(0, 99) < 85;
            op.issued  = $urandom_range(0, 99) < 80;
            op.bypass  = $urandom_range(0, 99) < 15;
            op.noncore = $urandom_range(0, 99) < 25;
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: anywhere in the address and sequence space
                op.seq  = rand48();
                op.addr = rand48();
                op.size = slafc_pkg::SIZE_W'($urandom_range(0, 64));
            end
            else
            begin
                op.seq  = seq_base + slafc_pkg::SEQ_W'($urandom_range(0, 40));
                op.addr = bases[$urandom_range(0, 3)] + slafc_pkg::ADDR_W'($urandom_range(0, 160));
                case ($urandom_range(0, 3))
                    0: op.size = slafc_pkg::SIZE_W'($urandom_range(0, 64));
                    1: op.size = 7'd1 << $urandom_range(0, 6);
                    2: op.size = 7'd64;
                    default: op.size = slafc_pkg::SIZE_W'($urandom_range(0, 8));
                endcase
            end
            queue_op(op);
        end
    endtask

    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (pending_ops.size() != 0 || s_tvalid || expected_flushes.size() != 0);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                op_on_bus = pending_ops[0];
                pending_ops.delete(0);
                s_tdata  <= {1'b0, op_on_bus.noncore, op_on_bus.bypass, op_on_bus.issued,
                             op_on_bus.size, op_on_bus.addr, op_on_bus.seq, op_on_bus.fill,
                             op_on_bus.slot};
                s_tuser  <= op_on_bus.func;
                s_tvalid <= 1'b1;
                tx_wait = tx_steady ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0)
                    tx_steady = !tx_steady;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                results_seen++;
                // long back-pressure stretch while the sender keeps offering
                if (results_seen == HOLD_AFTER)
                    hold_left = RESULT_HOLD;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0)
                    rx_steady = !rx_steady;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        flush_result_t want;
        if (rst_n)
        begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (s_tvalid && s_tready)
                expected_flushes = {expected_flushes, step_load_table(op_on_bus)};
            if (m_tvalid && m_tready)
            begin
                if (expected_flushes.size() == 0)
                begin
                    $error("unexpected result transaction: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_flushes[0];
                    expected_flushes.delete(0);
                    if (m_tdata[0] !== want.found)
                    begin
                        $error("alias_found: expected %0d, got %0d", want.found, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[48:1] !== want.oldest)
                    begin
                        $error("oldest_alias_seq: expected %h, got %h", want.oldest, m_tdata[48:1]);
                        mismatches++;
                    end
                    if (m_tdata[64:49] !== want.mask)
                    begin
                        $error("flush_mask: expected %h, got %h", want.mask, m_tdata[64:49]);
                        mismatches++;
                    end
                    if (m_tdata[65] !== want.dep)
                    begin
                        $error("dep_forces_flush: expected %0d, got %0d", want.dep, m_tdata[65]);
                        mismatches++;
                    end
                    if (m_tdata[66] !== want.err)
                    begin
                        $error("bypass_alias_error: expected %0d, got %0d", want.err, m_tdata[66]);
                        mismatches++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= IDLE_LIMIT)
                begin
                    $display("timeout: no transaction in %0d cycles", IDLE_LIMIT);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_op(check_op(48'h0, 64));
        queue_op(write_op(0, 1, 48'd100, 48'h1000, 8, 1, 0, 0));
        queue_op(write_op(15, 1, {slafc_pkg::SEQ_W{1'b1}}, 48'hFFFF_FFFF_FFC0, 64, 1, 0, 0));
        queue_op(write_op(1, 1, 48'd50, 48'h1004, 4, 1, 1, 0));
        queue_op(write_op(2, 1, 48'd200, 48'h2000, 16, 1, 0, 1));
        queue_op(write_op(3, 1, 48'd300, 48'h5000, 8, 0, 0, 0));
        queue_op(check_op(48'h1000, 8));
        // zero-size store inside a load, and at its first byte
        queue_op(check_op(48'h2008, 0));
        queue_op(check_op(48'h2000, 0));
        // ranges running past the top of the address space
        queue_op(check_op({slafc_pkg::ADDR_W{1'b1}}, 64));
        queue_op(check_op(48'h1000, 64));
        queue_op(check_op(48'h5000, 8));
        queue_op(write_op(4, 1, 48'd0, 48'h0, 0, 1, 0, 0));
        queue_op(check_op(48'h0, 1));
        queue_op(write_op(5, 1, 48'd100, 48'h1000, 1, 1, 0, 1));
        queue_op(check_op(48'h1000, 2));
        queue_op(write_op(2, 0, {slafc_pkg::SEQ_W{1'b1}}, {slafc_pkg::ADDR_W{1'b1}},
                          64, 1, 1, 1));
        queue_op(check_op(48'h2000, 16));
        queue_op(write_op(2, 1, 48'd150, 48'h2000, 16, 1, 0, 0));
        queue_op(check_op(48'h0FF8, 64));
        queue_op(write_op(1, 0, 48'd0, 48'h0, 0, 0, 0, 0));
        queue_op(check_op(48'h1000, 8));
        wait_until_drained();

        repeat (CHUNKS)
        begin
            queue_random_ops(CHUNK_OPS);
            wait_until_drained();
        end
        repeat (ENTRIES + 8) @(posedge clk);

        $display("covered %0d slot writes and %0d store checks, %0d loads flagged for flush",
                 write_count, check_count, flushed_lds);
        $display("%0d checks aliased, %0d with non-core dependents, %0d hit bypassed loads",
                 alias_checks, dep_checks, err_checks);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
